// ===== rtl/bhc_pkg.sv =====
// shared constants, tables and types for the blended heat capacity interpolator
`default_nettype none
package bhc_pkg;

  localparam int unsigned TEMP_W = 16;
  localparam int unsigned P_W    = 17;
  localparam int unsigned HC_W   = 16;
  localparam int unsigned GRID_N = 29;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned FRAC_W = 11;
  localparam int unsigned E_W    = 17;
  localparam int unsigned D_W    = 18;
  localparam int unsigned V_W    = 27;
  localparam int unsigned VS_W   = 30;
  localparam int unsigned PROD_W = 44;
  localparam int unsigned Z_W    = 25;
  localparam int unsigned ZM_W   = 51;
  localparam int unsigned ZM_SH  = 35;

  localparam logic [TEMP_W-1:0] T_LOW    = 16'd4800;
  localparam logic [TEMP_W-1:0] T_HIGH   = 16'd49600;
  localparam logic [TEMP_W-1:0] STEP     = 16'd1600;
  localparam logic [IDX_W-1:0]  LAST_SEG = 5'd27;
  localparam logic [P_W-1:0]    P_ONE    = 17'd65536;

  // floor(x / 25) for x below 1024
  localparam logic [20:0] RECIP_25 = 21'd1311;
  // floor(z / 625) for z below 2**25
  localparam logic [ZM_W-1:0] RECIP_625 = 51'd54975582;
  localparam logic [PROD_W-1:0] ROUND_HALF = 44'd81920000;

  // entries in hundredths of J/(kg K)
  localparam logic [E_W-1:0] TAB_A [GRID_N] = '{
    17'd23551, 17'd26579, 17'd28214, 17'd29221, 17'd29911, 17'd30424, 17'd30832, 17'd31174,
    17'd31476, 17'd31759, 17'd32044, 17'd32360, 17'd32741, 17'd33231, 17'd33877, 17'd34730,
    17'd35840, 17'd37254, 17'd39012, 17'd41146, 17'd43678, 17'd46621, 17'd49980, 17'd53750,
    17'd57917, 17'd62463, 17'd67363, 17'd72588, 17'd78108
  };

  localparam logic [E_W-1:0] TAB_B [GRID_N] = '{
    17'd20371, 17'd22579, 17'd23577, 17'd24133, 17'd24492, 17'd24747, 17'd24944, 17'd25104,
    17'd25243, 17'd25370, 17'd25496, 17'd25632, 17'd25793, 17'd25993, 17'd26247, 17'd26567,
    17'd26957, 17'd27417, 17'd27935, 17'd28496, 17'd29080, 17'd29670, 17'd30247, 17'd30800,
    17'd31321, 17'd31808, 17'd32259, 17'd32676, 17'd33064
  };

  typedef struct packed {
    logic s2;
    logic s3;
  } lerp_en_t;

endpackage
`default_nettype wire

// ===== rtl/bhc_lerp.sv =====
// two pipeline stages of linear interpolation between two table entries
`default_nettype none
module bhc_lerp (
  input  wire logic                         clk_i,
  input  wire bhc_pkg::lerp_en_t            en_i,
  input  wire logic [bhc_pkg::E_W-1:0]      lo_i,
  input  wire logic [bhc_pkg::E_W-1:0]      hi_i,
  input  wire logic [bhc_pkg::FRAC_W-1:0]   frac_i,
  output logic      [bhc_pkg::V_W-1:0]      v_o
);
  import bhc_pkg::*;

  logic        [E_W-1:0]    lo_q;
  logic signed [D_W-1:0]    diff_q, diff_d;
  logic        [FRAC_W-1:0] frac_q;
  logic        [V_W-1:0]    v_q, v_d;
  logic signed [VS_W-1:0]   base_s, step_s, sum_s;

  assign diff_d = $signed({1'b0, hi_i}) - $signed({1'b0, lo_i});

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      lo_q   <= lo_i;
      diff_q <= diff_d;
      frac_q <= frac_i;
    end
  end

  always_comb begin
    base_s = $signed(VS_W'(lo_q)) * $signed(VS_W'(STEP));
    step_s = $signed(VS_W'(frac_q)) * VS_W'(diff_q);
    sum_s  = base_s + step_s;
    v_d    = sum_s[VS_W-1] ? '0 : sum_s[V_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule
`default_nettype wire

// ===== rtl/blended_heat_capacity_interp_top.sv =====
// top level of the blended heat capacity interpolator
`default_nettype none
// Takes one temperature word (unsigned Q12.4 kelvin) per cycle when the output is not
// stalled and returns one heat capacity word (unsigned Q10.6 J/(kg K), rounded to
// nearest) for each one. Two 29-point tables on a 100 K grid from
// 300 K to 3100 K are interpolated linearly and held flat outside the grid, then
// blended by the plutonium fraction register (Q1.16, values above one act as one).
// The path is seven register stages: segment search, table read, interpolation,
// blend multiply, sum and rounding, reciprocal multiply for the final scaling,
// output register. Each stage holds only while the one after it is full and
// stalled, so bubbles close up; with no output stall one word per cycle flows.
module blended_heat_capacity_interp_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bhc_pkg::P_W-1:0]     cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bhc_pkg::TEMP_W-1:0]  temperature_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [bhc_pkg::HC_W-1:0]    heat_capacity_o
);
  import bhc_pkg::*;

  localparam int unsigned NST = 7;

  logic [P_W-1:0] pu_fraction_q;
  logic [NST-1:0] valid_q, valid_d, ready;

  // stage 1
  logic              lo1, hi1;
  logic [TEMP_W-1:0] t1;
  logic [20:0]       seg_prod;
  logic              lo_q, hi_q;
  logic [TEMP_W-1:0] t_q;
  logic [IDX_W-1:0]  idx_q;

  // stage 2
  logic [TEMP_W-1:0] off2, rem2;
  logic [IDX_W-1:0]  idx2, idx2n;
  logic [FRAC_W-1:0] frac2;
  lerp_en_t          lerp_en;

  // stage 3 outputs
  logic [V_W-1:0] va, vb;

  // stage 4
  logic [P_W-1:0]    psat, pinv;
  logic [PROD_W-1:0] prod_a_q, prod_b_q;

  // stage 5 to 7
  logic [PROD_W-1:0] sum5;
  logic [Z_W-1:0]    z_q;
  logic [ZM_W-1:0]   zm_q;
  logic [HC_W-1:0]   hc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pu_fraction_q <= '0;
    end else if (cfg_we_i) begin
      pu_fraction_q <= cfg_wdata_i;
    end
  end

  // pipeline control
  always_comb begin
    ready[NST-1] = !valid_q[NST-1] || !out_stall_i;
    for (int k = NST-2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NST; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NST-1];

  // segment search
  always_comb begin
    lo1      = temperature_i <= T_LOW;
    hi1      = temperature_i >= T_HIGH;
    t1       = temperature_i - T_LOW;
    seg_prod = 21'(t1[TEMP_W-1:6]) * RECIP_25;
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      lo_q  <= lo1;
      hi_q  <= hi1;
      t_q   <= t1;
      idx_q <= seg_prod[19:15];
    end
  end

  // fraction within segment and clamping
  always_comb begin
    off2 = TEMP_W'(idx_q) * STEP;
    rem2 = t_q - off2;
    if (lo_q) begin
      idx2  = '0;
      frac2 = '0;
    end else if (hi_q) begin
      idx2  = LAST_SEG;
      frac2 = STEP[FRAC_W-1:0];
    end else begin
      idx2  = idx_q;
      frac2 = rem2[FRAC_W-1:0];
    end
    idx2n      = idx2 + IDX_W'(1);
    lerp_en.s2 = ready[1];
    lerp_en.s3 = ready[2];
  end

  bhc_lerp u_lerp_a (
    .clk_i  (clk_i),
    .en_i   (lerp_en),
    .lo_i   (TAB_A[idx2]),
    .hi_i   (TAB_A[idx2n]),
    .frac_i (frac2),
    .v_o    (va)
  );

  bhc_lerp u_lerp_b (
    .clk_i  (clk_i),
    .en_i   (lerp_en),
    .lo_i   (TAB_B[idx2]),
    .hi_i   (TAB_B[idx2n]),
    .frac_i (frac2),
    .v_o    (vb)
  );

  // blend weights
  always_comb begin
    psat = (pu_fraction_q > P_ONE) ? P_ONE : pu_fraction_q;
    pinv = P_ONE - psat;
  end

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      prod_a_q <= PROD_W'(pinv) * PROD_W'(va);
      prod_b_q <= PROD_W'(psat) * PROD_W'(vb);
    end
  end

  // round, drop the 2**18 part of the 163840000 divisor
  assign sum5 = prod_a_q + prod_b_q + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      z_q <= sum5[Z_W+17:18];
    end
  end

  // remaining division by 625
  always_ff @(posedge clk_i) begin
    if (ready[5]) begin
      zm_q <= ZM_W'(z_q) * RECIP_625;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[6]) begin
      hc_q <= zm_q[ZM_W-1:ZM_SH];
    end
  end

  assign heat_capacity_o = hc_q;

endmodule
`default_nettype wire
